### design/ptld_pkg.sv
// ptld_pkg: shared types and constants for the point to line distance core
// request and result structs, coordinate width and the line case codes
// no dependencies
package ptld_pkg;

  localparam int COORD_W = 32;
  localparam int TOL_W   = 16;

  typedef enum logic [1:0] {
    CASE_VERT = 2'd0,
    CASE_HORZ = 2'd1,
    CASE_GEN  = 2'd2
  } line_case_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] line_ax;
    logic signed [COORD_W-1:0] line_ay;
    logic signed [COORD_W-1:0] line_bx;
    logic signed [COORD_W-1:0] line_by;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } ptld_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] foot_x;
    logic signed [COORD_W-1:0] foot_y;
    logic        [COORD_W-1:0] dist_res;
    line_case_t                line_case;
  } ptld_res_t;

endpackage

### design/ptld_div.sv
// ptld_div: pipelined restoring divider, one quotient bit per stage
// flags overflow when the quotient does not fit in QUO_W bits
// no package dependencies
module ptld_div #(
  parameter int NUM_W = 99,
  parameter int DEN_W = 67,
  parameter int QUO_W = 34
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             ovf
);

  logic [DEN_W-1:0] rem   [0:QUO_W];
  logic [QUO_W-1:0] low   [0:QUO_W];
  logic [QUO_W-1:0] q     [0:QUO_W];
  logic             ov    [0:QUO_W];
  logic [DEN_W-1:0] den_s [0:QUO_W];
  logic [DEN_W:0]   trial [0:QUO_W-1];
  logic [DEN_W:0]   diff  [0:QUO_W-1];
  logic             fit   [0:QUO_W-1];
  logic [NUM_W-1:0] hi;
  logic             hi_ov;

  assign hi    = num >> QUO_W;
  assign hi_ov = hi >= NUM_W'(den);

  always_comb begin
    for (int i = 0; i < QUO_W; i++) begin
      trial[i] = {rem[i], low[i][QUO_W-1]};
      diff[i]  = trial[i] - {1'b0, den_s[i]};
      fit[i]   = trial[i] >= {1'b0, den_s[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ov[0]    <= hi_ov;
      rem[0]   <= hi_ov ? '0 : hi[DEN_W-1:0];
      low[0]   <= num[QUO_W-1:0];
      q[0]     <= '0;
      den_s[0] <= den;
      for (int i = 0; i < QUO_W; i++) begin
        rem[i+1]   <= fit[i] ? diff[i][DEN_W-1:0] : trial[i][DEN_W-1:0];
        low[i+1]   <= low[i] << 1;
        q[i+1]     <= {q[i][QUO_W-2:0], fit[i]};
        ov[i+1]    <= ov[i];
        den_s[i+1] <= den_s[i];
      end
    end
  end

  assign quo = q[QUO_W];
  assign ovf = ov[QUO_W];

endmodule

### design/point_to_line_distance_core.sv
// point_to_line_distance_core: foot of the perpendicular and distance, 2d
// depends on ptld_pkg and ptld_div
//
// requests come in on req with req_valid/req_ready, results leave on res
// with res_valid/res_ready. each request carries two points of a line and
// a point, signed fixed point; each gives exactly one result in order.
// the tolerance register is written through cfg_wr_en/cfg_wr_data and
// resets to zero; the user must write it only while the block is idle,
// which the block itself does not enforce. one request is taken every
// cycle unless the output stalls. seven stages of differences, products
// and sums feed a bit per stage restoring divider for the squared
// distance (2*COORD_W+1 stages) and a two bits per stage square root
// (COORD_W stages); two foot dividers run alongside, delayed to match.
// reset clears all valid bits and the tolerance. when res_ready is low
// with a result waiting the whole pipeline holds and req_ready drops;
// bubbles in flight move along with the requests and are not squeezed out.
module point_to_line_distance_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [ptld_pkg::TOL_W-1:0] cfg_wr_data,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  ptld_pkg::ptld_req_t        req,
  output logic                       res_valid,
  input  logic                       res_ready,
  output ptld_pkg::ptld_res_t        res
);
  import ptld_pkg::*;

  localparam int W    = COORD_W;
  localparam int LW   = 2*W + 2;
  localparam int CW   = 2*W + 3;
  localparam int CLW  = W + 2;
  localparam int H    = W + 1;
  localparam int PW   = 3*W + 3;
  localparam int NFW  = 3*W + 3;
  localparam int DFW  = 2*W + 3;
  localparam int QFW  = W + 2;
  localparam int NDW  = 4*W + 4;
  localparam int QDW  = 2*W;
  localparam int T    = QDW + 1 + W;
  localparam int FD   = T - (QFW + 1);

  typedef struct packed {
    line_case_t          lcase;
    logic signed [W-1:0] sfx;
    logic signed [W-1:0] sfy;
    logic [W-1:0]        sdist;
    logic signed [W-1:0] px;
    logic signed [W-1:0] py;
    logic                negx;
    logic                negy;
  } side_t;

  function automatic logic signed [W-1:0] sat_coord(input logic signed [W+2:0] v);
    logic [3:0] top;
    top = v[W+2:W-1];
    if (top == '0 || top == '1) begin
      return v[W-1:0];
    end else if (v[W+2]) begin
      return {1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  logic [TOL_W-1:0] tol;
  logic             en;

  logic v1, v2, v3, v4, v5, v6, v7;
  logic vd [0:T-1];

  ptld_req_t r1;

  logic signed [W:0] dx_c, dy_c, ex_c, ey_c;
  logic [W:0]        adx_c, ady_c, aex_c, aey_c, tol_x;
  side_t             side_c;

  logic signed [W:0] dx2, dy2, ex2, ey2;
  side_t             side2, side3, side4, side5, side6, side7;
  side_t             side7_c;
  side_t             side_d [0:T-1];

  logic signed [2*W+1:0] sqx3, sqy3, pa3, pb3;
  logic signed [W:0]     dx3, dy3;

  logic [LW-1:0]         len4;
  logic signed [CW-1:0]  c4;
  logic signed [W:0]     dx4, dy4;
  logic [CW-1:0]         ca4;

  logic signed [2*W+3:0] pxl5, pyl5;
  logic signed [2*W+1:0] pxh5, pyh5;
  logic [2*H-1:0]        hh5, hl5, ll5;
  logic [LW-1:0]         len5;

  logic signed [PW-1:0]  px6, py6;
  logic [NDW-1:0]        c2_6;
  logic [LW-1:0]         len6;

  logic [PW-1:0]         mx_c, my_c;
  logic [NFW-1:0]        nfx7, nfy7;
  logic [DFW-1:0]        df7;
  logic [NDW-1:0]        nd7;
  logic [LW-1:0]         dd7;

  logic [QFW-1:0]        qx, qy;
  logic                  qx_ov, qy_ov;
  logic [QFW-1:0]        qx_d [0:FD-1];
  logic [QFW-1:0]        qy_d [0:FD-1];
  logic [QDW-1:0]        d2_q;
  logic                  d2_ov;

  logic [W+1:0]          srem  [0:W];
  logic [W-1:0]          sroot [0:W];
  logic [QDW-1:0]        sval  [0:W];
  logic                  sov   [0:W];
  logic [W+3:0]          st    [0:W-1];
  logic [W+3:0]          strl  [0:W-1];
  logic [W+3:0]          sdif  [0:W-1];
  logic                  sfit  [0:W-1];

  side_t                 so;
  logic signed [W+2:0]   fx_c, fy_c;
  ptld_res_t             res_c;

  assign en        = !res_valid || res_ready;
  assign req_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0;
    end else if (cfg_wr_en) begin
      tol <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      for (int i = 0; i < T; i++) vd[i] <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      vd[0] <= v7;
      for (int i = 1; i < T; i++) vd[i] <= vd[i-1];
      res_valid <= vd[T-1];
    end
  end

  // case test and the vertical and horizontal answers
  always_comb begin
    dx_c  = {r1.line_bx[W-1], r1.line_bx} - {r1.line_ax[W-1], r1.line_ax};
    dy_c  = {r1.line_by[W-1], r1.line_by} - {r1.line_ay[W-1], r1.line_ay};
    ex_c  = {r1.point_x[W-1], r1.point_x} - {r1.line_ax[W-1], r1.line_ax};
    ey_c  = {r1.point_y[W-1], r1.point_y} - {r1.line_ay[W-1], r1.line_ay};
    adx_c = dx_c[W] ? -dx_c : dx_c;
    ady_c = dy_c[W] ? -dy_c : dy_c;
    aex_c = ex_c[W] ? -ex_c : ex_c;
    aey_c = ey_c[W] ? -ey_c : ey_c;
    tol_x = (W+1)'(tol);
    side_c       = '0;
    side_c.px    = r1.point_x;
    side_c.py    = r1.point_y;
    if (adx_c <= tol_x) begin
      side_c.lcase = CASE_VERT;
      side_c.sfx   = r1.line_ax;
      side_c.sfy   = r1.point_y;
      side_c.sdist = aex_c[W-1:0];
    end else if (ady_c <= tol_x) begin
      side_c.lcase = CASE_HORZ;
      side_c.sfx   = r1.point_x;
      side_c.sfy   = r1.line_ay;
      side_c.sdist = aey_c[W-1:0];
    end else begin
      side_c.lcase = CASE_GEN;
    end
  end

  always_comb begin
    mx_c = px6[PW-1] ? PW'(-px6) : PW'(px6);
    my_c = py6[PW-1] ? PW'(-py6) : PW'(py6);
    ca4  = c4[CW-1] ? CW'(-c4) : CW'(c4);
  end

  // signs of the foot offsets travel with the side data
  always_comb begin
    side7_c      = side6;
    side7_c.negx = px6[PW-1];
    side7_c.negy = py6[PW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1 <= req;

      dx2   <= dx_c;
      dy2   <= dy_c;
      ex2   <= ex_c;
      ey2   <= ey_c;
      side2 <= side_c;

      sqx3  <= dx2 * dx2;
      sqy3  <= dy2 * dy2;
      pa3   <= ex2 * dy2;
      pb3   <= ey2 * dx2;
      dx3   <= dx2;
      dy3   <= dy2;
      side3 <= side2;

      len4  <= LW'($unsigned(sqx3)) + LW'($unsigned(sqy3));
      c4    <= CW'(pa3) - CW'(pb3);
      dx4   <= dx3;
      dy4   <= dy3;
      side4 <= side3;

      pxl5  <= dy4 * $signed({1'b0, c4[CLW-1:0]});
      pxh5  <= dy4 * $signed(c4[CW-1:CLW]);
      pyl5  <= dx4 * $signed({1'b0, c4[CLW-1:0]});
      pyh5  <= dx4 * $signed(c4[CW-1:CLW]);
      hh5   <= ca4[2*H-1:H] * ca4[2*H-1:H];
      hl5   <= ca4[2*H-1:H] * ca4[H-1:0];
      ll5   <= ca4[H-1:0] * ca4[H-1:0];
      len5  <= len4;
      side5 <= side4;

      px6   <= (PW'(pxh5) <<< CLW) + PW'(pxl5);
      py6   <= (PW'(pyh5) <<< CLW) + PW'(pyl5);
      c2_6  <= (NDW'(hh5) << (2*H)) + (NDW'(hl5) << (H+1)) + NDW'(ll5);
      len6  <= len5;
      side6 <= side5;

      nfx7  <= (NFW'(mx_c) << 1) + NFW'(len6);
      nfy7  <= (NFW'(my_c) << 1) + NFW'(len6);
      df7   <= DFW'(len6) << 1;
      nd7   <= c2_6;
      dd7   <= len6;
      side7 <= side7_c;

      side_d[0] <= side7;
      for (int i = 1; i < T; i++) side_d[i] <= side_d[i-1];
      qx_d[0] <= qx;
      qy_d[0] <= qy;
      for (int i = 1; i < FD; i++) begin
        qx_d[i] <= qx_d[i-1];
        qy_d[i] <= qy_d[i-1];
      end
    end
  end

  ptld_div #(.NUM_W(NFW), .DEN_W(DFW), .QUO_W(QFW)) u_div_fx (
    .clk (clk),
    .en  (en),
    .num (nfx7),
    .den (df7),
    .quo (qx),
    .ovf (qx_ov)
  );

  ptld_div #(.NUM_W(NFW), .DEN_W(DFW), .QUO_W(QFW)) u_div_fy (
    .clk (clk),
    .en  (en),
    .num (nfy7),
    .den (df7),
    .quo (qy),
    .ovf (qy_ov)
  );

  ptld_div #(.NUM_W(NDW), .DEN_W(LW), .QUO_W(QDW)) u_div_d2 (
    .clk (clk),
    .en  (en),
    .num (nd7),
    .den (dd7),
    .quo (d2_q),
    .ovf (d2_ov)
  );

  // square root, two radicand bits per stage
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sval[0]  = d2_q;
  assign sov[0]   = d2_ov;

  always_comb begin
    for (int i = 0; i < W; i++) begin
      st[i]   = {srem[i], sval[i][QDW-1:QDW-2]};
      strl[i] = {2'b00, sroot[i], 2'b01};
      sdif[i] = st[i] - strl[i];
      sfit[i] = st[i] >= strl[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < W; i++) begin
        srem[i+1]  <= sfit[i] ? sdif[i][W+1:0] : st[i][W+1:0];
        sroot[i+1] <= {sroot[i][W-2:0], sfit[i]};
        sval[i+1]  <= sval[i] << 2;
        sov[i+1]   <= sov[i];
      end
    end
  end

  always_comb begin
    so   = side_d[T-1];
    fx_c = so.negx ? {{3{so.px[W-1]}}, so.px} + $signed({1'b0, qx_d[FD-1]})
                   : {{3{so.px[W-1]}}, so.px} - $signed({1'b0, qx_d[FD-1]});
    fy_c = so.negy ? {{3{so.py[W-1]}}, so.py} - $signed({1'b0, qy_d[FD-1]})
                   : {{3{so.py[W-1]}}, so.py} + $signed({1'b0, qy_d[FD-1]});
    res_c.line_case = so.lcase;
    case (so.lcase)
      CASE_GEN: begin
        res_c.foot_x   = sat_coord(fx_c);
        res_c.foot_y   = sat_coord(fy_c);
        res_c.dist_res = sov[W] ? '1 : sroot[W];
      end
      default: begin
        res_c.foot_x   = so.sfx;
        res_c.foot_y   = so.sfy;
        res_c.dist_res = so.sdist;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_c;
    end
  end

  a_req_enters: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> v1)
    else $error("accepted request did not enter the first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(v7) && $stable(vd[T-1])))
    else $error("pipeline moved during a stall");

  a_out_follows: assert property (@(posedge clk) disable iff (rst)
    en |=> (res_valid == $past(vd[T-1])))
    else $error("result valid does not follow the last stage");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  a_foot_fits: assert property (@(posedge clk) disable iff (rst)
    (vd[QFW] && side_d[QFW].lcase == CASE_GEN) |-> !(qx_ov || qy_ov))
    else $error("foot quotient does not fit");

endmodule
